[src/h2r_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_pkg: shared constants of the HSV to RGB converter
// Field widths, fixed-point scale factors and hue sector codes.
// ----------------------------------------------------------------------------
package h2r_pkg;

	localparam int HUE_W  = 11;
	localparam int FRAC_W = 9;
	localparam int CH_W   = 8;
	localparam int SEC_W  = 3;

	// A channel fraction is held in units of 2^-24, so 1.0 needs 25 bits.
	localparam int CH_FRAC_BITS = 24;
	localparam int X_W          = CH_FRAC_BITS + 1;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 9'd256;

	// Output scale 255.9 is carried as 2559 / 10.
	localparam int SCALE_W = 12;
	localparam logic [SCALE_W-1:0] CH_SCALE = 12'd2559;
	localparam int PROD_W = X_W + SCALE_W;

	// floor(n / 10) = (n * 52429) >> 19, exact for every n below 43699.
	localparam int DIV_MUL_W = 16;
	localparam logic [DIV_MUL_W-1:0] DIV10_MUL = 16'd52429;
	localparam int DIV10_SHIFT = 19;
	localparam int QUOT_W = SCALE_W + DIV_MUL_W;

	typedef logic [SEC_W-1:0] sector_t;
	localparam sector_t SEC_RED_YEL = 3'd0;
	localparam sector_t SEC_YEL_GRN = 3'd1;
	localparam sector_t SEC_GRN_CYN = 3'd2;
	localparam sector_t SEC_CYN_BLU = 3'd3;
	localparam sector_t SEC_BLU_MAG = 3'd4;

endpackage

[src/hsv_to_rgb_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: pipelined HSV to RGB pixel converter
// Four register stages: clamp and sector products, channel products,
// sector selection and scaling, divide by ten into the output register.
// ----------------------------------------------------------------------------
// The converter takes one HSV pixel per transaction and returns one RGB
// transaction for it, in order. It accepts a pixel on every clock cycle
// unless the pipe is full and its output is held off. Each pixel passes
// through four register stages; its result is shown on red, green and blue
// from the last. The depth follows the chain of products: each stage holds
// one multiplication with a register behind it. When the output is held off
// the stages behind it keep filling empty slots, so up to four pixels can be
// in flight and the input stalls only once all four stages are occupied.
// Hue carries the sector in bits 10..8 and the fraction within the sector in
// bits 7..0; sectors six and seven use the sector-five mapping. Saturation
// and value treat 256 as 1.0 and are clamped to it. Zero saturation gives
// grey. Each channel is floor(x * 255.9), formed exactly in fixed point.
module hsv_to_rgb_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          hsv_valid,
	output logic                          hsv_ready,
	input  logic [h2r_pkg::HUE_W-1:0]     hue,
	input  logic [h2r_pkg::FRAC_W-1:0]    saturation,
	input  logic [h2r_pkg::FRAC_W-1:0]    value,
	output logic                          rgb_valid,
	input  logic                          rgb_ready,
	output logic [h2r_pkg::CH_W-1:0]      red,
	output logic [h2r_pkg::CH_W-1:0]      green,
	output logic [h2r_pkg::CH_W-1:0]      blue
);

	localparam int FW  = h2r_pkg::FRAC_W;
	localparam int XW  = h2r_pkg::X_W;
	localparam int PW  = h2r_pkg::PROD_W;
	localparam int QW  = h2r_pkg::QUOT_W;
	localparam int DW  = 2 * FW - 1;   // width of s*f and of 65536 - s*f

	// Each stage moves forward when it is empty or the next stage moves.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	assign en4 = !valid_s4 || rgb_ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign hsv_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= hsv_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: clamp saturation and value, form s*f and s*(1-f).
	logic [FW-1:0] sat_c, val_c, nf_c;
	logic [DW-1:0] sf_c, snf_c;

	always_comb begin
		sat_c = (saturation > h2r_pkg::FRAC_ONE) ? h2r_pkg::FRAC_ONE : saturation;
		val_c = (value > h2r_pkg::FRAC_ONE) ? h2r_pkg::FRAC_ONE : value;
		nf_c  = h2r_pkg::FRAC_ONE - {1'b0, hue[7:0]};
		sf_c  = DW'(sat_c) * DW'(hue[7:0]);
		snf_c = DW'(sat_c) * DW'(nf_c);
	end

	logic [FW-1:0]          val_s1, ns_s1;
	logic [DW-1:0]          sf_s1, snf_s1;
	h2r_pkg::sector_t       sector_s1;
	logic                   grey_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			val_s1    <= val_c;
			ns_s1     <= h2r_pkg::FRAC_ONE - sat_c;
			sf_s1     <= sf_c;
			snf_s1    <= snf_c;
			sector_s1 <= hue[h2r_pkg::HUE_W-1:8];
			grey_s1   <= (sat_c == '0);
		end
	end

	// Stage 2: the four candidate channels in units of 2^-24.
	logic [DW-1:0] dq_c, dt_c;
	logic [XW-1:0] px_c;

	always_comb begin
		dq_c = {1'b1, {(DW-1){1'b0}}} - sf_s1;
		dt_c = {1'b1, {(DW-1){1'b0}}} - snf_s1;
		px_c = (XW'(val_s1) * XW'(ns_s1)) << 8;
	end

	logic [XW-1:0]    vx_s2, px_s2, qx_s2, tx_s2;
	h2r_pkg::sector_t sector_s2;
	logic             grey_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			vx_s2     <= {val_s1, 16'h0000};
			px_s2     <= px_c;
			qx_s2     <= XW'(val_s1) * XW'(dq_c);
			tx_s2     <= XW'(val_s1) * XW'(dt_c);
			sector_s2 <= sector_s1;
			grey_s2   <= grey_s1;
		end
	end

	// Stage 3: assign channels per sector and scale by 2559.
	logic [XW-1:0] r_c, g_c, b_c;

	always_comb begin
		if (grey_s2) begin
			r_c = vx_s2;
			g_c = vx_s2;
			b_c = vx_s2;
		end else begin
			case (sector_s2)
				h2r_pkg::SEC_RED_YEL: begin
					r_c = vx_s2; g_c = tx_s2; b_c = px_s2;
				end
				h2r_pkg::SEC_YEL_GRN: begin
					r_c = qx_s2; g_c = vx_s2; b_c = px_s2;
				end
				h2r_pkg::SEC_GRN_CYN: begin
					r_c = px_s2; g_c = vx_s2; b_c = tx_s2;
				end
				h2r_pkg::SEC_CYN_BLU: begin
					r_c = px_s2; g_c = qx_s2; b_c = vx_s2;
				end
				h2r_pkg::SEC_BLU_MAG: begin
					r_c = tx_s2; g_c = px_s2; b_c = vx_s2;
				end
				default: begin
					// Sector five, and the unused sectors six and seven.
					r_c = vx_s2; g_c = px_s2; b_c = qx_s2;
				end
			endcase
		end
	end

	logic [PW-1:0] rp_s3, gp_s3, bp_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			rp_s3 <= PW'(r_c) * PW'(h2r_pkg::CH_SCALE);
			gp_s3 <= PW'(g_c) * PW'(h2r_pkg::CH_SCALE);
			bp_s3 <= PW'(b_c) * PW'(h2r_pkg::CH_SCALE);
		end
	end

	// Stage 4: drop the 2^-24 fraction, then divide by ten with a reciprocal.
	localparam int NHI = h2r_pkg::CH_FRAC_BITS + h2r_pkg::SCALE_W - 1;
	localparam int QLO = h2r_pkg::DIV10_SHIFT;
	localparam int QHI = QLO + h2r_pkg::CH_W - 1;

	logic [QW-1:0] rq_c, gq_c, bq_c;

	always_comb begin
		rq_c = QW'(rp_s3[NHI:h2r_pkg::CH_FRAC_BITS]) * QW'(h2r_pkg::DIV10_MUL);
		gq_c = QW'(gp_s3[NHI:h2r_pkg::CH_FRAC_BITS]) * QW'(h2r_pkg::DIV10_MUL);
		bq_c = QW'(bp_s3[NHI:h2r_pkg::CH_FRAC_BITS]) * QW'(h2r_pkg::DIV10_MUL);
	end

	logic [h2r_pkg::CH_W-1:0] red_s4, green_s4, blue_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			red_s4   <= rq_c[QHI:QLO];
			green_s4 <= gq_c[QHI:QLO];
			blue_s4  <= bq_c[QHI:QLO];
		end
	end

	assign rgb_valid = valid_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;

	// The input can only be held off when the output is stalled.
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!hsv_ready |-> (rgb_valid && !rgb_ready))
		else $error("input stalled while the output is free");

	// The candidate channels p, q and t never exceed 1.0 in units of 2^-24.
	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (px_s2 <= XW'(1 << 24) && qx_s2 <= XW'(1 << 24)
			&& tx_s2 <= XW'(1 << 24)))
		else $error("candidate channel above full scale");

	// The scaled channel always fits the 8-bit result.
	a_quotient_fits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (rq_c[QW-1:QHI+1] == '0 && gq_c[QW-1:QHI+1] == '0
			&& bq_c[QW-1:QHI+1] == '0))
		else $error("scaled channel overflows eight bits");

	// A stalled result keeps its slot valid on the next cycle.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !rgb_ready) |=> valid_s4)
		else $error("stalled result dropped");

endmodule

[bench/hsv_to_rgb_converter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test: self-checking bench for the HSV to RGB converter
// Drives pixels through the valid/ready input, predicts each RGB result in
// exact fixed point and checks the returned transactions in order. Both sides
// idle in random bursts, and the output is held off once to fill the pipe.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;

	typedef struct packed {
		logic [h2r_pkg::CH_W-1:0] red;
		logic [h2r_pkg::CH_W-1:0] green;
		logic [h2r_pkg::CH_W-1:0] blue;
	} rgb_t;

	// Holds the colors expected from the converter, oldest first, and works
	// out each one from the pixel that was accepted.
	class rgb_scoreboard;
		rgb_t expected_rgb[$];
		int   failures;
		int   pixels_in;
		int   pixels_out;
		int   grey_pixels;
		int   clamped_pixels;
		int   wrapped_sectors;

		// Map a channel fraction in units of 2^-24 to an 8-bit level.
		function logic [h2r_pkg::CH_W-1:0] channel_level(longint unsigned x);
			longint unsigned scaled;
			scaled = (x * h2r_pkg::CH_SCALE) / (64'd10 << h2r_pkg::CH_FRAC_BITS);
			return scaled[h2r_pkg::CH_W-1:0];
		endfunction

		function rgb_t convert(logic [h2r_pkg::HUE_W-1:0] hue,
				logic [h2r_pkg::FRAC_W-1:0] sat, logic [h2r_pkg::FRAC_W-1:0] val);
			longint unsigned s, v, f, one, vx, px, qx, tx, rx, gx, bx;
			h2r_pkg::sector_t sec;
			rgb_t    color;
			one = h2r_pkg::FRAC_ONE;
			s   = (sat > h2r_pkg::FRAC_ONE) ? one : sat;
			v   = (val > h2r_pkg::FRAC_ONE) ? one : val;
			sec = hue[h2r_pkg::HUE_W-1:h2r_pkg::HUE_W-h2r_pkg::SEC_W];
			f   = hue[7:0];
			vx  = v << 16;
			if (s == 0) begin
				rx = vx;
				gx = vx;
				bx = vx;
			end else begin
				px = (v * (one - s)) << 8;
				qx = v * (one * one - s * f);
				tx = v * (one * one - s * (one - f));
				case (sec)
					h2r_pkg::SEC_RED_YEL: begin rx = vx; gx = tx; bx = px; end
					h2r_pkg::SEC_YEL_GRN: begin rx = qx; gx = vx; bx = px; end
					h2r_pkg::SEC_GRN_CYN: begin rx = px; gx = vx; bx = tx; end
					h2r_pkg::SEC_CYN_BLU: begin rx = px; gx = qx; bx = vx; end
					h2r_pkg::SEC_BLU_MAG: begin rx = tx; gx = px; bx = vx; end
					default:              begin rx = vx; gx = px; bx = qx; end
				endcase
			end
			color.red   = channel_level(rx);
			color.green = channel_level(gx);
			color.blue  = channel_level(bx);
			return color;
		endfunction

		function void note_pixel(logic [h2r_pkg::HUE_W-1:0] hue,
				logic [h2r_pkg::FRAC_W-1:0] sat, logic [h2r_pkg::FRAC_W-1:0] val);
			expected_rgb.push_back(convert(hue, sat, val));
			pixels_in++;
			if (sat == 0)
				grey_pixels++;
			if (sat > h2r_pkg::FRAC_ONE || val > h2r_pkg::FRAC_ONE)
				clamped_pixels++;
			if (hue[h2r_pkg::HUE_W-1:h2r_pkg::HUE_W-2] == 2'b11)
				wrapped_sectors++;
		endfunction

		function void check_pixel(logic [h2r_pkg::CH_W-1:0] red,
				logic [h2r_pkg::CH_W-1:0] green, logic [h2r_pkg::CH_W-1:0] blue);
			rgb_t want;
			pixels_out++;
			if (expected_rgb.size() == 0) begin
				failures++;
				$display("%0t: unexpected result r=%0d g=%0d b=%0d", $time, red, green, blue);
				return;
			end
			want = expected_rgb.pop_front();
			if (red !== want.red) begin
				failures++;
				$display("%0t: red expected %0d actual %0d", $time, want.red, red);
			end
			if (green !== want.green) begin
				failures++;
				$display("%0t: green expected %0d actual %0d", $time, want.green, green);
			end
			if (blue !== want.blue) begin
				failures++;
				$display("%0t: blue expected %0d actual %0d", $time, want.blue, blue);
			end
		endfunction
	endclass

	localparam int RESET_CYCLES = 5;
	localparam int HOLD_CYCLES  = 40;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 10;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          hsv_valid;
	logic                          hsv_ready;
	logic [h2r_pkg::HUE_W-1:0]     hue;
	logic [h2r_pkg::FRAC_W-1:0]    saturation;
	logic [h2r_pkg::FRAC_W-1:0]    value;
	logic                          rgb_valid;
	logic                          rgb_ready;
	logic [h2r_pkg::CH_W-1:0]      red;
	logic [h2r_pkg::CH_W-1:0]      green;
	logic [h2r_pkg::CH_W-1:0]      blue;

	// Switches that the main sequence flips between phases of the run.
	bit sender_idles   = 1'b0;
	bit receiver_idles = 1'b0;
	bit hold_request   = 1'b0;
	int holds_done     = 0;

	rgb_scoreboard board = new();

	hsv_to_rgb_converter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.value      (value),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always #1 clk = ~clk;

	// Drop valid for the given number of cycles. The next send raises it on
	// a later falling edge, so valid never sees two updates in one step.
	task automatic sender_pause(input int cycles);
		@(negedge clk);
		hsv_valid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// Offer one pixel and wait for its input transaction. Valid is raised on
	// a falling edge and stays up with a steady payload until the rising edge
	// that sees ready; the accepted pixel then goes to the scoreboard.
	task automatic send_pixel(input logic [h2r_pkg::HUE_W-1:0] h,
			input logic [h2r_pkg::FRAC_W-1:0] s, input logic [h2r_pkg::FRAC_W-1:0] v);
		@(negedge clk);
		hsv_valid  <= 1'b1;
		hue        <= h;
		saturation <= s;
		value      <= v;
		do
			@(posedge clk);
		while (!hsv_ready);
		board.note_pixel(h, s, v);
		// A burst of idle cycles on the input side, now and then.
		if (sender_idles && $urandom_range(0, 5) == 0)
			sender_pause($urandom_range(1, 9));
	endtask

	// Saturation and value mostly stay in their nominal range, with a share
	// of values above 1.0 to exercise the clamp and extra zeros for grey.
	function automatic logic [h2r_pkg::FRAC_W-1:0] random_fraction(input bit grey_bias);
		if (grey_bias && $urandom_range(0, 15) == 0)
			return '0;
		if ($urandom_range(0, 4) == 0)
			return h2r_pkg::FRAC_W'($urandom_range(0, (1 << h2r_pkg::FRAC_W) - 1));
		return h2r_pkg::FRAC_W'($urandom_range(0, h2r_pkg::FRAC_ONE));
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(h2r_pkg::HUE_W'($urandom_range(0, (1 << h2r_pkg::HUE_W) - 1)),
				random_fraction(1'b1), random_fraction(1'b0));
	endtask

	// Output side. The ready line changes only on falling edges. A pending
	// hold request keeps ready low for a long stretch, counted here, so the
	// pipe fills and the converter stalls its input; otherwise ready drops
	// for short random bursts while idling is enabled.
	initial begin
		rgb_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				rgb_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1)
					@(negedge clk);
				hold_request = 1'b0;
				holds_done++;
			end else if (receiver_idles && $urandom_range(0, 6) == 0) begin
				rgb_ready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1)
					@(negedge clk);
			end else begin
				rgb_ready <= 1'b1;
			end
		end
	end

	// Every output transaction is checked at the rising edge that accepts it.
	always @(posedge clk)
		if (arst_n && rgb_valid && rgb_ready)
			board.check_pixel(red, green, blue);

	// Main sequence.
	initial begin
		int waited;
		arst_n     = 1'b0;
		hsv_valid  = 1'b0;
		hue        = '0;
		saturation = '0;
		value      = '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed pixels: both ends of every sector at full saturation and
		// brightness, then grey, black, clamped inputs and small fractions.
		for (int sec = 0; sec < 8; sec++) begin
			send_pixel({h2r_pkg::SEC_W'(sec), 8'h00}, h2r_pkg::FRAC_ONE, h2r_pkg::FRAC_ONE);
			send_pixel({h2r_pkg::SEC_W'(sec), 8'hff}, h2r_pkg::FRAC_ONE, h2r_pkg::FRAC_ONE);
		end
		send_pixel(11'h000, 9'd0, h2r_pkg::FRAC_ONE);
		send_pixel(11'h7ff, 9'd0, 9'd0);
		send_pixel(11'h2a5, h2r_pkg::FRAC_ONE, 9'd0);
		send_pixel(11'h180, 9'd257, 9'd511);
		send_pixel(11'h555, 9'd511, 9'd300);
		send_pixel(11'h080, 9'd1, 9'd1);
		send_pixel(11'h480, 9'd255, 9'd255);
		send_pixel(11'h3ff, 9'd128, h2r_pkg::FRAC_ONE);

		// Random pixels with idle bursts on both sides.
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		send_random(300);

		// Back-pressure: the output is held off while pixels keep coming, so
		// the pipe fills and the input must stall until the hold ends.
		sender_idles = 1'b0;
		hold_request = 1'b1;
		send_random(30);

		sender_idles = 1'b1;
		send_random(300);

		// Last stretch at full rate with no idling on either side.
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		send_random(250);

		@(negedge clk);
		hsv_valid <= 1'b0;

		waited = 0;
		while (board.expected_rgb.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES)
			@(posedge clk);

		if (board.expected_rgb.size() != 0) begin
			board.failures++;
			$display("%0t: %0d expected results never arrived", $time,
				board.expected_rgb.size());
		end

		$display("Converted %0d pixels, %0d results checked, %0d output holds.",
			board.pixels_in, board.pixels_out, holds_done);
		$display("Included %0d grey, %0d clamped and %0d sector six or seven pixels.",
			board.grey_pixels, board.clamped_pixels, board.wrapped_sectors);
		if (board.failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#400000;
		$display("Timeout: the run did not complete.");
		$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
src/h2r_pkg.sv
src/hsv_to_rgb_converter.sv
bench/hsv_to_rgb_converter_test.sv
